@@ hdl/gwwlb_pkg.sv @@
// Shared codes, widths and job size for the greedy word-wrap line breaker.
`default_nettype none
package gwwlb_pkg;

  localparam int CLASS_BITS     = 2;
  localparam int BYTES_BITS     = 3;
  localparam int ADV_BITS       = 8;
  localparam int WIDTH_BITS     = 12;
  localparam int CFG_INDEX_BITS = 1;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RESET = 12'd304;

  localparam logic [CLASS_BITS-1:0] CLS_ORDINARY = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLS_SPACE    = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLS_BREAK    = 2'd2;
  localparam logic [CLASS_BITS-1:0] CLS_END      = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_WIDTH       = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_AT_SPACES = 1'd1;

  // job: result count (2), base line index, three results of bytes + sep + done
  function automatic int job_bits(input int cb);
    return 2 + cb + 3 * (cb + 2);
  endfunction

endpackage
`default_nettype wire

@@ hdl/gwwlb_front.sv @@
// Front part: config registers, line state, classifies each character into a job.
`default_nettype none
module gwwlb_front #(
  parameter int COUNT_BITS = 12
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_write,
  input  logic [gwwlb_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [gwwlb_pkg::WIDTH_BITS-1:0]             cfg_data,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [gwwlb_pkg::CLASS_BITS-1:0]             char_class,
  input  logic [gwwlb_pkg::BYTES_BITS-1:0]             char_bytes,
  input  logic [gwwlb_pkg::ADV_BITS-1:0]               char_advance,
  output logic                                         push,
  output logic [gwwlb_pkg::job_bits(COUNT_BITS)-1:0]   job,
  input  logic                                         full
);
  import gwwlb_pkg::*;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bytes;
    logic                  sep;
    logic                  done;
  } result_t;

  typedef struct packed {
    logic [1:0]            count;
    logic [COUNT_BITS-1:0] base;
    result_t [2:0]         res;
  } job_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] lw;
    logic [COUNT_BITS-1:0] lbc;
    logic [COUNT_BITS-1:0] bbs;
    logic [COUNT_BITS-1:0] bas;
    logic [WIDTH_BITS-1:0] was;
  } line_t;

  logic [WIDTH_BITS-1:0] max_width;
  logic                  break_at_spaces;
  line_t                 line, line_next;
  logic [COUNT_BITS-1:0] line_counter, line_counter_next;
  job_t                  j;
  logic                  accept;

  logic [COUNT_BITS-1:0] nb;
  logic [WIDTH_BITS-1:0] adv;
  logic [WIDTH_BITS:0]   mw13, w0, w1, wn;
  logic                  fit0, fit1, fitn, marks;
  logic [COUNT_BITS:0]   lbc_sum, bas_sum, lc_sum;
  logic [COUNT_BITS-1:0] lbc_plus, bas_plus;
  line_t                 fresh;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (j.count != 2'd0);
  assign job      = j;

  assign nb   = {{(COUNT_BITS-BYTES_BITS){1'b0}}, char_bytes};
  assign adv  = {{(WIDTH_BITS-ADV_BITS){1'b0}}, char_advance};
  assign mw13 = {1'b0, max_width};
  assign w0   = {1'b0, line.lw} + {1'b0, adv};
  assign w1   = {1'b0, line.was} + {1'b0, adv};
  assign wn   = {1'b0, adv};
  assign fit0 = w0 <= mw13;
  assign fit1 = w1 <= mw13;
  assign fitn = wn <= mw13;
  assign marks = (char_class == CLS_SPACE) && break_at_spaces && (line.lbc != '0);

  assign lbc_sum  = {1'b0, line.lbc} + {1'b0, nb};
  assign bas_sum  = {1'b0, line.bas} + {1'b0, nb};
  assign lbc_plus = lbc_sum[COUNT_BITS] ? '1 : lbc_sum[COUNT_BITS-1:0];
  assign bas_plus = bas_sum[COUNT_BITS] ? '1 : bas_sum[COUNT_BITS-1:0];

  assign fresh = '{lw: adv, lbc: nb, bbs: '0, bas: nb, was: adv};

  always_comb begin
    line_next = line;
    j         = '0;
    j.base    = line_counter;
    case (char_class)
      CLS_BREAK: begin
        j.res[0]  = '{bytes: line.lbc, sep: 1'b1, done: 1'b0};
        j.count   = 2'd1;
        line_next = '0;
      end
      CLS_END: begin
        if (line.lbc != '0) begin
          j.res[0] = '{bytes: line.lbc, sep: 1'b0, done: 1'b0};
          j.res[1] = '{bytes: '0, sep: 1'b0, done: 1'b1};
          j.count  = 2'd2;
        end else begin
          j.res[0] = '{bytes: '0, sep: 1'b0, done: 1'b1};
          j.count  = 2'd1;
        end
        line_next = '0;
      end
      default: begin
        if (fit0) begin
          line_next.lw  = w0[WIDTH_BITS-1:0];
          line_next.lbc = lbc_plus;
          if (marks) begin
            line_next.bbs = line.lbc;
            line_next.bas = '0;
            line_next.was = '0;
          end else begin
            line_next.bas = bas_plus;
            line_next.was = line.was + adv;
          end
        end else if (marks) begin
          // overflowing space ends the line at itself
          j.res[0]  = '{bytes: line.lbc, sep: 1'b1, done: 1'b0};
          j.count   = 2'd1;
          line_next = '0;
        end else if (line.bbs != '0) begin
          j.res[0] = '{bytes: line.bbs, sep: 1'b1, done: 1'b0};
          if (fit1) begin
            line_next = '{lw: w1[WIDTH_BITS-1:0], lbc: bas_plus, bbs: '0, bas: nb, was: adv};
            j.count   = 2'd1;
          end else if (line.bas == '0) begin
            j.res[1]  = '{bytes: nb, sep: 1'b0, done: 1'b0};
            j.count   = 2'd2;
            line_next = '0;
          end else begin
            j.res[1] = '{bytes: line.bas, sep: 1'b0, done: 1'b0};
            if (fitn) begin
              line_next = fresh;
              j.count   = 2'd2;
            end else begin
              j.res[2]  = '{bytes: nb, sep: 1'b0, done: 1'b0};
              j.count   = 2'd3;
              line_next = '0;
            end
          end
        end else if (line.lbc == '0) begin
          // too wide for any line: a line of its own
          j.res[0]  = '{bytes: nb, sep: 1'b0, done: 1'b0};
          j.count   = 2'd1;
          line_next = '0;
        end else begin
          j.res[0] = '{bytes: line.lbc, sep: 1'b0, done: 1'b0};
          if (fitn) begin
            line_next = fresh;
            j.count   = 2'd1;
          end else begin
            j.res[1]  = '{bytes: nb, sep: 1'b0, done: 1'b0};
            j.count   = 2'd2;
            line_next = '0;
          end
        end
      end
    endcase
  end

  assign lc_sum = {1'b0, line_counter} + {{(COUNT_BITS-1){1'b0}}, j.count};

  always_comb begin
    if (char_class == CLS_END) begin
      line_counter_next = '0;
    end else begin
      line_counter_next = lc_sum[COUNT_BITS] ? '1 : lc_sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width       <= MAX_WIDTH_RESET;
      break_at_spaces <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_WIDTH:       max_width       <= cfg_data;
        REG_BREAK_AT_SPACES: break_at_spaces <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line         <= '0;
      line_counter <= '0;
    end else if (accept) begin
      line         <= line_next;
      line_counter <= line_counter_next;
    end
  end

  a_end_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && (char_class == CLS_END) |-> push)
    else $error("end of text gave no transaction");

  a_break_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && (char_class == CLS_BREAK) |-> push && (j.count == 2'd1))
    else $error("newline did not give exactly one line");

  a_fit_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (char_class == CLS_ORDINARY || char_class == CLS_SPACE) && fit0 |-> !push)
    else $error("fitting character produced a line");

endmodule
`default_nettype wire

@@ hdl/gwwlb_queue.sv @@
// Short FIFO of jobs between the front and back parts.
`default_nettype none
module gwwlb_queue #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = count == CNT_BITS'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !empty)
    else $error("queue empty after push");

endmodule
`default_nettype wire

@@ hdl/gwwlb_back.sv @@
// Back part: walks the results of the head job into the output register.
`default_nettype none
module gwwlb_back #(
  parameter int COUNT_BITS = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [gwwlb_pkg::job_bits(COUNT_BITS)-1:0] head,
  input  logic                                       empty,
  output logic                                       pop,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [COUNT_BITS-1:0]                      line_bytes,
  output logic                                       separator_bytes,
  output logic [COUNT_BITS-1:0]                      line_index,
  output logic                                       text_done,
  output logic                                       last_of_run
);
  import gwwlb_pkg::*;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bytes;
    logic                  sep;
    logic                  done;
  } result_t;

  typedef struct packed {
    logic [1:0]            count;
    logic [COUNT_BITS-1:0] base;
    result_t [2:0]         res;
  } job_t;

  job_t                  j;
  result_t               sel;
  logic [1:0]            pos;
  logic                  load, last;
  logic [COUNT_BITS:0]   idx_sum;
  logic [COUNT_BITS-1:0] idx;

  assign j    = head;
  assign load = !empty && (!out_valid || out_ready);
  assign last = pos == (j.count - 2'd1);
  assign pop  = load && last;

  always_comb begin
    case (pos)
      2'd1:    sel = j.res[1];
      2'd2:    sel = j.res[2];
      default: sel = j.res[0];
    endcase
  end

  assign idx_sum = {1'b0, j.base} + {{(COUNT_BITS-1){1'b0}}, pos};
  assign idx     = idx_sum[COUNT_BITS] ? '1 : idx_sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= last ? 2'd0 : pos + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_bytes      <= sel.bytes;
      separator_bytes <= sel.sep;
      line_index      <= idx;
      text_done       <= sel.done;
      last_of_run     <= last;
    end
  end

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> last_of_run)
    else $error("end-of-text record is not last of its run");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> (line_bytes == '0) && !separator_bytes)
    else $error("end-of-text record carries a line");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pos < j.count)
    else $error("result position past job count");

endmodule
`default_nettype wire

@@ hdl/greedy_word_wrap_line_breaker.sv @@
// Greedy word-wrap line breaker: use and timing of the block.
//
// Input channel (in_valid/in_ready): one character per transaction with its
// class, UTF-8 byte count and pixel advance. Output channel
// (out_valid/out_ready): one line record per transaction; an input causes
// zero to three records, the final one flagged by last_of_run.
// Configuration: cfg_write with cfg_index/cfg_data, taken at once; the user must
// write only while no transactions are outstanding (the block does not enforce it).
// Timing: with the queue and output idle, a taken character's job is written
// into the queue and its first record is then loaded into the output register;
// its further records follow one per cycle while the receiver is ready.
// Throughput: one character per cycle on the input; one record per cycle on
// the output, set by the single output register. A four-job queue between
// the front and back parts absorbs characters that cause several records;
// in_ready drops only while that queue is full.
// Reset (rst, synchronous): registers return to max_width 304 and
// break_at_spaces 1, line state and counter clear, queue and output empty.
// A stalled receiver holds the output record; the queue then fills and the
// input side stalls in turn.
`default_nettype none
module greedy_word_wrap_line_breaker #(
  parameter int COUNT_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [gwwlb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gwwlb_pkg::WIDTH_BITS-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gwwlb_pkg::CLASS_BITS-1:0]     char_class,
  input  logic [gwwlb_pkg::BYTES_BITS-1:0]     char_bytes,
  input  logic [gwwlb_pkg::ADV_BITS-1:0]       char_advance,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [COUNT_BITS-1:0]                line_bytes,
  output logic                                 separator_bytes,
  output logic [COUNT_BITS-1:0]                line_index,
  output logic                                 text_done,
  output logic                                 last_of_run
);
  import gwwlb_pkg::*;

  localparam int JOB_W = job_bits(COUNT_BITS);

  logic             push, full, pop, empty;
  logic [JOB_W-1:0] job, head;

  gwwlb_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_class   (char_class),
    .char_bytes   (char_bytes),
    .char_advance (char_advance),
    .push         (push),
    .job          (job),
    .full         (full)
  );

  gwwlb_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  gwwlb_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .line_bytes      (line_bytes),
    .separator_bytes (separator_bytes),
    .line_index      (line_index),
    .text_done       (text_done),
    .last_of_run     (last_of_run)
  );

endmodule
`default_nettype wire

@@ test/wrap_checker.sv @@
`timescale 1ns / 1ps
// Line record checker: predicts the breaker's records per character and compares them.
module wrap_checker #(
  parameter int COUNT_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [gwwlb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gwwlb_pkg::WIDTH_BITS-1:0]     cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [gwwlb_pkg::CLASS_BITS-1:0]     char_class,
  input  logic [gwwlb_pkg::BYTES_BITS-1:0]     char_bytes,
  input  logic [gwwlb_pkg::ADV_BITS-1:0]       char_advance,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [COUNT_BITS-1:0]                line_bytes,
  input  logic                                 separator_bytes,
  input  logic [COUNT_BITS-1:0]                line_index,
  input  logic                                 text_done,
  input  logic                                 last_of_run,
  output int                                   errors,
  output int                                   pending,
  output int                                   records
);
  import gwwlb_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bytes;
    logic                  sep;
    logic [COUNT_BITS-1:0] index;
    logic                  done;
    logic                  last;
  } line_rec_t;

  logic [WIDTH_BITS-1:0] width_limit;
  logic                  spaces_break;
  logic [WIDTH_BITS:0]   run_width;
  logic [COUNT_BITS-1:0] run_bytes;
  logic [COUNT_BITS-1:0] space_at;
  logic [COUNT_BITS-1:0] tail_bytes;
  logic [WIDTH_BITS:0]   tail_width;
  logic [COUNT_BITS-1:0] line_no;

  line_rec_t recs_due[$];
  line_rec_t burst[3];
  int        burst_n;
  int        mism = 0;
  int        seen = 0;

  initial begin
    errors  = 0;
    pending = 0;
    records = 0;
  end

  function automatic logic [COUNT_BITS-1:0] sat_sum(input logic [COUNT_BITS-1:0] a,
                                                    input int unsigned b);
    int unsigned s;
    s = 32'(a) + b;
    return (s > 32'(COUNT_TOP)) ? COUNT_TOP : s[COUNT_BITS-1:0];
  endfunction

  task automatic clear_line();
    run_width  = '0;
    run_bytes  = '0;
    space_at   = '0;
    tail_bytes = '0;
    tail_width = '0;
  endtask

  task automatic close_line(input logic [COUNT_BITS-1:0] nbytes, input logic sep,
                            input logic done);
    burst[burst_n] = '{bytes: nbytes, sep: sep, index: line_no, done: done, last: 1'b0};
    burst_n++;
    if (!done) line_no = sat_sum(line_no, 1);
  endtask

  task automatic fit_char(input logic is_space, input logic [BYTES_BITS-1:0] nb,
                          input logic [ADV_BITS-1:0] adv);
    logic [COUNT_BITS-1:0] at;
    logic                  marks;
    logic                  settled;
    int unsigned           w;
    settled = 1'b0;
    for (int pass = 0; pass < 3 && !settled; pass++) begin
      at    = run_bytes;
      marks = is_space && spaces_break && (at != 0);
      if (marks) begin
        space_at   = at;
        tail_bytes = '0;
        tail_width = '0;
      end
      w = 32'(run_width) + 32'(adv);
      if (w <= 32'(width_limit)) begin
        run_width = w[WIDTH_BITS:0];
        run_bytes = sat_sum(at, 32'(nb));
        if (!marks) begin
          tail_bytes = sat_sum(tail_bytes, 32'(nb));
          tail_width = tail_width + (WIDTH_BITS+1)'(adv);
        end
        settled = 1'b1;
      end else if (space_at != 0) begin
        // break at the last space, the space itself is dropped
        close_line(space_at, 1'b1, 1'b0);
        if (marks) begin
          clear_line();
          settled = 1'b1;
        end else begin
          run_width  = tail_width;
          run_bytes  = tail_bytes;
          space_at   = '0;
          tail_bytes = '0;
          tail_width = '0;
        end
      end else if (at == 0) begin
        // too wide for any line: it stands alone
        close_line(COUNT_BITS'(nb), 1'b0, 1'b0);
        clear_line();
        settled = 1'b1;
      end else begin
        close_line(at, 1'b0, 1'b0);
        clear_line();
      end
    end
  endtask

  task automatic take_char(input logic [CLASS_BITS-1:0] cls, input logic [BYTES_BITS-1:0] nb,
                           input logic [ADV_BITS-1:0] adv);
    burst_n = 0;
    case (cls)
      CLS_BREAK: begin
        close_line(run_bytes, 1'b1, 1'b0);
        clear_line();
      end
      CLS_END: begin
        if (run_bytes != 0) close_line(run_bytes, 1'b0, 1'b0);
        close_line('0, 1'b0, 1'b1);
        clear_line();
        line_no = '0;
      end
      default: fit_char(cls == CLS_SPACE, nb, adv);
    endcase
    if (burst_n > 0) burst[burst_n-1].last = 1'b1;
    for (int k = 0; k < burst_n; k++) recs_due.insert(recs_due.size(), burst[k]);
  endtask

  always @(posedge clk) begin
    line_rec_t want;
    if (rst) begin
      width_limit  = MAX_WIDTH_RESET;
      spaces_break = 1'b1;
      clear_line();
      line_no = '0;
      recs_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen++;
        if (recs_due.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected line record: bytes=%0d sep=%0b index=%0d done=%0b last=%0b",
                     line_bytes, separator_bytes, line_index, text_done, last_of_run);
        end else begin
          want = recs_due.pop_front();
          if (line_bytes !== want.bytes || separator_bytes !== want.sep ||
              line_index !== want.index || text_done !== want.done ||
              last_of_run !== want.last) begin
            mism++;
            if (mism <= 10)
              $display("record %0d mismatch: exp bytes=%0d sep=%0b index=%0d done=%0b last=%0b",
                       seen, want.bytes, want.sep, want.index, want.done, want.last,
                       "  got bytes=%0d sep=%0b index=%0d done=%0b last=%0b",
                       line_bytes, separator_bytes, line_index, text_done, last_of_run);
          end
        end
      end
      if (in_valid && in_ready) take_char(char_class, char_bytes, char_advance);
      if (cfg_write) begin
        case (cfg_index)
          REG_MAX_WIDTH:       width_limit  = cfg_data;
          REG_BREAK_AT_SPACES: spaces_break = cfg_data[0];
          default: ;
        endcase
      end
    end
    errors  <= mism;
    pending <= recs_due.size();
    records <= seen;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: drives text, register settings and backpressure into the line breaker.
module tb_top;
  import gwwlb_pkg::*;

  localparam int COUNT_BITS  = 12;
  localparam int STALL_LIMIT = 4000;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_write    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [WIDTH_BITS-1:0]     cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [CLASS_BITS-1:0]     char_class   = '0;
  logic [BYTES_BITS-1:0]     char_bytes   = '0;
  logic [ADV_BITS-1:0]       char_advance = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [COUNT_BITS-1:0]     line_bytes;
  logic                      separator_bytes;
  logic [COUNT_BITS-1:0]     line_index;
  logic                      text_done;
  logic                      last_of_run;

  int errors;
  int pending;
  int records;
  int chars_sent = 0;
  int settings   = 0;
  int stuck      = 0;
  bit steady     = 1'b0;
  bit hold_off   = 1'b0;

  always #5 clk = ~clk;

  greedy_word_wrap_line_breaker #(.COUNT_BITS(COUNT_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_class(char_class), .char_bytes(char_bytes), .char_advance(char_advance),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_bytes(line_bytes), .separator_bytes(separator_bytes), .line_index(line_index),
    .text_done(text_done), .last_of_run(last_of_run)
  );

  wrap_checker #(.COUNT_BITS(COUNT_BITS)) u_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_class(char_class), .char_bytes(char_bytes), .char_advance(char_advance),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_bytes(line_bytes), .separator_bytes(separator_bytes), .line_index(line_index),
    .text_done(text_done), .last_of_run(last_of_run),
    .errors(errors), .pending(pending), .records(records)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (hold_off) begin
        stall    = 64;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic [BYTES_BITS-1:0] pick_bytes();
    return ($urandom_range(0, 9) == 0) ? BYTES_BITS'($urandom_range(0, 7))
                                       : BYTES_BITS'($urandom_range(1, 4));
  endfunction

  function automatic logic [ADV_BITS-1:0] pick_advance(input int top);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 4) return ADV_BITS'($urandom_range(0, 255));
    return ADV_BITS'($urandom_range(1, top));
  endfunction

  task automatic send_char(input logic [CLASS_BITS-1:0] cls, input logic [BYTES_BITS-1:0] nb,
                           input logic [ADV_BITS-1:0] adv);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    char_class   <= cls;
    char_bytes   <= nb;
    char_advance <= adv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [WIDTH_BITS-1:0] limit, input logic spaces);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_WIDTH;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_index <= REG_BREAK_AT_SPACES;
    cfg_data  <= WIDTH_BITS'(spaces);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // mostly words and spaces, some line ends and text ends, a little noise
  task automatic random_text(input int n, input int top);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 58) send_char(CLS_ORDINARY, pick_bytes(), pick_advance(top));
      else if (r < 78) send_char(CLS_SPACE, pick_bytes(), pick_advance(top));
      else if (r < 88) send_char(CLS_BREAK, pick_bytes(), pick_advance(top));
      else if (r < 92) send_char(CLS_END, pick_bytes(), pick_advance(top));
      else send_char(CLASS_BITS'($urandom_range(0, 3)), BYTES_BITS'($urandom_range(0, 7)),
                     ADV_BITS'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input int limit, input logic spaces, input int top);
    drain();
    set_config(WIDTH_BITS'(limit), spaces);
    random_text(40, top);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: space breaks, multi-pass breaks, empty lines, end-of-text flush
    send_char(CLS_ORDINARY, 1, 8);
    send_char(CLS_SPACE,    1, 4);
    send_char(CLS_ORDINARY, 4, 255);
    send_char(CLS_ORDINARY, 2, 100);
    send_char(CLS_ORDINARY, 3, 255);
    send_char(CLS_BREAK,    1, 0);
    send_char(CLS_SPACE,    1, 10);
    send_char(CLS_BREAK,    1, 0);
    send_char(CLS_BREAK,    1, 0);
    send_char(CLS_ORDINARY, 1, 200);
    send_char(CLS_SPACE,    1, 200);
    send_char(CLS_END,      1, 0);
    send_char(CLS_ORDINARY, 0, 0);
    send_char(CLS_END,      1, 0);
    send_char(CLS_ORDINARY, 7, 255);
    send_char(CLS_END,      1, 0);

    // three records from one character
    drain();
    set_config(100, 1'b1);
    send_char(CLS_ORDINARY, 1, 10);
    send_char(CLS_SPACE,    1, 10);
    send_char(CLS_ORDINARY, 1, 80);
    send_char(CLS_ORDINARY, 1, 200);
    send_char(CLS_END,      1, 0);

    drain();
    set_config(1, 1'b0);
    send_char(CLS_ORDINARY, 4, 255);
    send_char(CLS_ORDINARY, 1, 1);
    send_char(CLS_ORDINARY, 2, 1);
    send_char(CLS_SPACE,    1, 1);
    send_char(CLS_END,      1, 0);

    drain();
    set_config(0, 1'b1);
    send_char(CLS_ORDINARY, 1, 0);
    send_char(CLS_ORDINARY, 1, 3);
    send_char(CLS_END,      1, 0);

    random_phase(304, 1'b1, 40);
    random_phase(4095, 1'b1, 255);
    random_phase(1, 1'b1, 2);
    random_phase($urandom_range(20, 120), 1'b0, 20);

    drain();
    set_config(WIDTH_BITS'($urandom_range(60, 400)), 1'b1);
    hold_off = 1'b1;
    steady   = 1'b1;
    repeat (12) send_char(CLS_BREAK, 1, 0);
    random_text(20, 60);
    steady = 1'b0;
    random_text(20, 60);

    random_phase($urandom_range(1, 4095), 1'($urandom_range(0, 1)), 255);
    drain();

    $display("ran %0d characters, %0d line records checked, %0d register settings",
             chars_sent, records, settings);
    $display("incl. overflow breaks, zero width and a stalled output");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hdl/gwwlb_pkg.sv
hdl/gwwlb_front.sv
hdl/gwwlb_queue.sv
hdl/gwwlb_back.sv
hdl/greedy_word_wrap_line_breaker.sv
test/wrap_checker.sv
test/tb_top.sv
